>>> design/dcmf_pkg.sv
// ----------------------------------------------------------------------------
// dcmf_pkg
// Shared types, constants and helpers of the dark channel minimum filter.
// ----------------------------------------------------------------------------
`default_nettype none

package dcmf_pkg;

	localparam int unsigned MAX_RADIUS_DEF = 7;
	localparam int unsigned MAX_WIDTH_DEF  = 2048;
	localparam int unsigned COORD_LIMIT    = 2048;
	localparam int unsigned CW             = 12;
	localparam int unsigned FIFO_DEPTH     = 8;
	localparam logic [16:0] FULL_SCALE_ROUND = 17'd65408;

	localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
	localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;
	localparam logic [2:0]  RADIUS_RST       = 3'd7;
	localparam logic        MODE_RST         = 1'b0;
	localparam logic [8:0]  FACTOR_RST       = 9'd243;

	localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [2:0] REG_RADIUS       = 3'd2;
	localparam logic [2:0] REG_MODE         = 3'd3;
	localparam logic [2:0] REG_FACTOR       = 3'd4;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic MODE_TRANS = 1'b1;

	localparam logic [1:0] SEL_HOLD  = 2'd0;
	localparam logic [1:0] SEL_SHIFT = 2'd1;
	localparam logic [1:0] SEL_LOAD  = 2'd2;

	typedef struct packed {
		logic       op;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  value;
		logic [10:0] out_row;
		logic [10:0] out_col;
		logic        last_of_frame;
	} out_word_t;

	typedef struct packed {
		logic [10:0] row;
		logic [10:0] col;
		logic        last;
	} pos_t;

	typedef struct packed {
		logic [1:0] sel;
		logic       hit;
		logic       cap;
		logic       col_en;
	} cell_ctl_t;

	// pairwise tree, five levels
	function automatic logic [7:0] min32(input logic [31:0][7:0] v);
		logic [31:0][7:0] t;
		int lv;
		int i;
		t = v;
		for (lv = 16; lv >= 1; lv = lv >> 1) begin
			for (i = 0; i < lv; i++) begin
				t[i] = (t[2*i] < t[2*i+1]) ? t[2*i] : t[2*i+1];
			end
		end
		return t[0];
	endfunction

endpackage

`default_nettype wire

>>> design/dark_channel_min_filter.sv
// ----------------------------------------------------------------------------
// dark_channel_min_filter
// Square-window minimum of per-pixel channel minima over a raster stream.
// ----------------------------------------------------------------------------
// One word is taken per clock unless stalled. Each pixel's channel minimum
// goes into a ring of 2*MAX_RADIUS+1 row memories; a row of 2*MAX_RADIUS+1
// column cells mirrors the window around the next output position, shifting
// one column per result and loading the next column from the memory read
// port, so a result is produced in the same word that completes its window
// and is queued after stages s1-s3. Input stalls only when eight results are
// in flight or queued. Row memories need no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dark_channel_min_filter import dcmf_pkg::*; #(
	parameter int unsigned MAX_RADIUS = MAX_RADIUS_DEF,
	parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_word_t    in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_word_t        out_data,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [11:0] cfg_data
);

	localparam int unsigned K    = MAX_RADIUS;
	localparam int unsigned N    = 2 * MAX_RADIUS + 1;
	localparam int unsigned NC   = 2 * MAX_RADIUS + 1;
	localparam int unsigned SW   = $clog2(N);
	localparam int unsigned SW1  = SW + 1;
	localparam int unsigned NW   = $clog2(N + 1);
	localparam int unsigned RW   = $clog2(MAX_RADIUS + 1);
	localparam int unsigned AW   = $clog2(MAX_WIDTH);
	localparam int unsigned WLIM = (MAX_WIDTH < COORD_LIMIT) ? MAX_WIDTH : COORD_LIMIT;

	logic [11:0] fw_q;
	logic [11:0] fh_q;
	logic [2:0]  wrad_q;
	logic        mode_q;
	logic [8:0]  fac_q;

	logic [10:0]   in_col_q, in_row_q, out_col_q, out_row_q;
	logic [SW-1:0] in_slot_q, out_slot_q;
	logic          ahead_q;

	logic [10:0]   in_col_n, in_row_n, out_col_n, out_row_n;
	logic [SW-1:0] in_slot_n, out_slot_n;
	logic          ahead_n;

	logic [CW-1:0] w_eff, h_eff, rr, cc, rlo;
	logic [RW-1:0] rad, dr;
	logic          accept, is_pix, wr_en, ready, emit, wrap, last_pos;
	logic          col_end_i, row_end_i, col_end_o, row_end_o;
	logic [7:0]    chmin;
	logic [NW-1:0] n_rows;
	logic [SW1-1:0] rlo_tmp, dslot;
	logic [SW-1:0] rlo_slot;
	logic [N-1:0]  slot_en;
	logic [NC-1:0] col_en, hit_w;
	logic [K:0]    hit_h;
	logic          hit_p;
	logic [1:0]    sel_c;
	logic [CW-1:0] col_off [NC];
	logic [AW-1:0] raddr, waddr;

	logic [7:0]        rdata [N];
	logic [N-1:0][7:0] p_eff;
	logic [N-1:0][7:0] cell_eff [NC];
	logic [N-1:0][7:0] head_eff [K+1];
	logic [NC-1:0][7:0] vmin_s1;
	logic              v_s1;
	pos_t              pos_s1;
	logic              full;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q   <= FRAME_WIDTH_RST;
			fh_q   <= FRAME_HEIGHT_RST;
			wrad_q <= RADIUS_RST;
			mode_q <= MODE_RST;
			fac_q  <= FACTOR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  fw_q   <= cfg_data;
				REG_FRAME_HEIGHT: fh_q   <= cfg_data;
				REG_RADIUS:       wrad_q <= cfg_data[2:0];
				REG_MODE:         mode_q <= cfg_data[0];
				REG_FACTOR:       fac_q  <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (fw_q == '0) begin
			w_eff = CW'(1);
		end else if (32'(fw_q) > WLIM) begin
			w_eff = CW'(WLIM);
		end else begin
			w_eff = fw_q;
		end
		if (fh_q == '0) begin
			h_eff = CW'(1);
		end else if (32'(fh_q) > COORD_LIMIT) begin
			h_eff = CW'(COORD_LIMIT);
		end else begin
			h_eff = fh_q;
		end
		rad = (32'(wrad_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(wrad_q);
	end

	// input side
	assign in_stall = full;
	assign accept   = in_valid && !in_stall;
	assign is_pix   = accept && in_data.op == OP_PIXEL && !ahead_q;
	assign wr_en    = is_pix && 32'(in_col_q) < MAX_WIDTH;
	assign waddr    = AW'(in_col_q);

	always_comb begin
		chmin = (in_data.blue < in_data.green) ? in_data.blue : in_data.green;
		if (in_data.red < chmin) begin
			chmin = in_data.red;
		end
	end

	assign col_end_i = (CW'(in_col_q) + CW'(1)) >= w_eff;
	assign row_end_i = (CW'(in_row_q) + CW'(1)) >= h_eff;

	always_comb begin
		in_col_n  = in_col_q;
		in_row_n  = in_row_q;
		in_slot_n = in_slot_q;
		ahead_n   = ahead_q;
		if (is_pix) begin
			if (col_end_i) begin
				in_col_n = '0;
				if (row_end_i) begin
					in_row_n  = '0;
					in_slot_n = '0;
					ahead_n   = 1'b1;
				end else begin
					in_row_n  = in_row_q + 11'd1;
					in_slot_n = (in_slot_q == SW'(N - 1)) ? '0 : in_slot_q + 1'b1;
				end
			end else begin
				in_col_n = in_col_q + 11'd1;
			end
		end
	end

	// readiness of the next output position, after this word's pixel
	always_comb begin
		rr = ((CW'(out_row_q) + CW'(rad)) > (h_eff - CW'(1))) ?
			(h_eff - CW'(1)) : (CW'(out_row_q) + CW'(rad));
		cc = ((CW'(out_col_q) + CW'(rad)) > (w_eff - CW'(1))) ?
			(w_eff - CW'(1)) : (CW'(out_col_q) + CW'(rad));
		ready = ahead_n || CW'(in_row_n) > rr || (CW'(in_row_n) == rr && CW'(in_col_n) > cc);
	end

	assign emit      = accept && ready;
	assign col_end_o = (CW'(out_col_q) + CW'(1)) >= w_eff;
	assign row_end_o = (CW'(out_row_q) + CW'(1)) >= h_eff;
	assign wrap      = emit && col_end_o;
	assign last_pos  = col_end_o && row_end_o;

	always_comb begin
		out_col_n  = out_col_q;
		out_row_n  = out_row_q;
		out_slot_n = out_slot_q;
		if (emit) begin
			if (col_end_o) begin
				out_col_n = '0;
				if (row_end_o) begin
					out_row_n  = '0;
					out_slot_n = '0;
				end else begin
					out_row_n  = out_row_q + 11'd1;
					out_slot_n = (out_slot_q == SW'(N - 1)) ? '0 : out_slot_q + 1'b1;
				end
			end else begin
				out_col_n = out_col_q + 11'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			ahead_q    <= 1'b0;
			v_s1       <= 1'b0;
		end else begin
			in_col_q   <= in_col_n;
			in_row_q   <= in_row_n;
			in_slot_q  <= in_slot_n;
			out_col_q  <= out_col_n;
			out_row_q  <= out_row_n;
			out_slot_q <= out_slot_n;
			ahead_q    <= (emit && last_pos) ? 1'b0 : ahead_n;
			v_s1       <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pos_s1 <= '{row: out_row_q, col: out_col_q, last: last_pos};
		end
	end

	// ring rows covered by the window
	always_comb begin
		dr = (CW'(out_row_q) > CW'(rad)) ? rad : RW'(out_row_q);
		rlo = CW'(out_row_q) - CW'(dr);
		n_rows = (rr >= rlo) ? NW'(rr - rlo + CW'(1)) : '0;
		rlo_tmp = SW1'(out_slot_q) + ((SW1'(out_slot_q) < SW1'(dr)) ? SW1'(N) : '0)
			- SW1'(dr);
		rlo_slot = SW'(rlo_tmp);
		for (int s = 0; s < N; s++) begin
			dslot = SW1'(s) + ((SW1'(s) < SW1'(rlo_slot)) ? SW1'(N) : '0) - SW1'(rlo_slot);
			slot_en[s] = dslot < SW1'(n_rows);
		end
	end

	// column cells hold columns out_col-K .. out_col+K; offsets carry +K
	always_comb begin
		for (int j = 0; j < NC; j++) begin
			col_off[j] = CW'(out_col_q) + CW'(j);
			col_en[j] = (32'(j) + 32'(rad) >= K) && (32'(j) <= K + 32'(rad)) &&
				(col_off[j] >= CW'(K)) &&
				({1'b0, col_off[j]} < ({1'b0, w_eff} + (CW+1)'(K)));
			hit_w[j] = wr_en && (CW'(in_col_q) + CW'(K) == col_off[j]);
		end
		for (int h = 0; h <= K; h++) begin
			hit_h[h] = wr_en && (in_col_q == 11'(h));
		end
		hit_p = wr_en && (CW'(in_col_q) == CW'(out_col_q) + CW'(K + 1));
		for (int s = 0; s < N; s++) begin
			p_eff[s] = (hit_p && in_slot_q == SW'(s)) ? chmin : rdata[s];
		end
		if (wrap) begin
			sel_c = SEL_LOAD;
		end else if (emit) begin
			sel_c = SEL_SHIFT;
		end else begin
			sel_c = SEL_HOLD;
		end
	end

	assign raddr = AW'(CW'(out_col_n) + CW'(K + 1));

	genvar gs, gj, gh;

	generate
		for (gs = 0; gs < N; gs++) begin : g_mem
			dcmf_row_mem #(.DEPTH(MAX_WIDTH), .AW(AW)) u_mem (
				.clk   (clk),
				.we    (wr_en && in_slot_q == SW'(gs)),
				.waddr (waddr),
				.wdata (chmin),
				.raddr (raddr),
				.rdata (rdata[gs])
			);
		end

		// fixed mirrors of the first columns, used at the start of each row
		for (gh = 0; gh <= K; gh++) begin : g_head
			dcmf_cell #(.N(N), .SW(SW)) u_head (
				.clk     (clk),
				.ctl     ('{sel: SEL_HOLD, hit: hit_h[gh], cap: 1'b0, col_en: 1'b0}),
				.wr_slot (in_slot_q),
				.wr_data (chmin),
				.nb      ('0),
				.ld      ('0),
				.slot_en ('0),
				.eff     (head_eff[gh]),
				.vmin_s1 ()
			);
		end

		for (gj = 0; gj < NC; gj++) begin : g_cell
			logic [N-1:0][7:0] nb_in;
			logic [N-1:0][7:0] ld_in;
			if (gj == NC - 1) begin : g_tail
				assign nb_in = p_eff;
			end else begin : g_mid
				assign nb_in = cell_eff[gj+1];
			end
			if (gj >= K) begin : g_ld
				assign ld_in = head_eff[gj-K];
			end else begin : g_keep
				assign ld_in = cell_eff[gj];
			end
			dcmf_cell #(.N(N), .SW(SW)) u_cell (
				.clk     (clk),
				.ctl     ('{sel: sel_c, hit: hit_w[gj], cap: emit, col_en: col_en[gj]}),
				.wr_slot (in_slot_q),
				.wr_data (chmin),
				.nb      (nb_in),
				.ld      (ld_in),
				.slot_en (slot_en),
				.eff     (cell_eff[gj]),
				.vmin_s1 (vmin_s1[gj])
			);
		end
	endgenerate

	dcmf_out #(.NC(NC)) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_s1      (v_s1),
		.pos_s1    (pos_s1),
		.vmin_s1   (vmin_s1),
		.emit      (emit),
		.mode      (mode_q),
		.factor    (fac_q),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.full      (full)
	);

endmodule

`default_nettype wire

>>> design/dcmf_row_mem.sv
// ----------------------------------------------------------------------------
// dcmf_row_mem
// One row of channel minima: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dcmf_row_mem import dcmf_pkg::*; #(
	parameter int unsigned DEPTH = MAX_WIDTH_DEF,
	parameter int unsigned AW    = $clog2(MAX_WIDTH_DEF)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic [7:0]         rdata
);

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// write-first so the read always sees the latest byte
		if (we && waddr == raddr) begin
			rdata <= wdata;
		end else begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/dcmf_cell.sv
// ----------------------------------------------------------------------------
// dcmf_cell
// One window column: a byte per ring row, snoops writes, shifts to its left
// neighbor, and captures the masked vertical minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module dcmf_cell import dcmf_pkg::*; #(
	parameter int unsigned N  = 2 * MAX_RADIUS_DEF + 1,
	parameter int unsigned SW = $clog2(2 * MAX_RADIUS_DEF + 1)
) (
	input  wire logic                clk,
	input  wire cell_ctl_t           ctl,
	input  wire logic [SW-1:0]       wr_slot,
	input  wire logic [7:0]          wr_data,
	input  wire logic [N-1:0][7:0]   nb,
	input  wire logic [N-1:0][7:0]   ld,
	input  wire logic [N-1:0]        slot_en,
	output logic [N-1:0][7:0]        eff,
	output logic [7:0]               vmin_s1
);

	logic [N-1:0][7:0] data_q;
	logic [31:0][7:0]  vin;

	always_comb begin
		for (int s = 0; s < N; s++) begin
			eff[s] = (ctl.hit && wr_slot == SW'(s)) ? wr_data : data_q[s];
		end
	end

	always_comb begin
		vin = '1;
		for (int s = 0; s < N; s++) begin
			if (slot_en[s]) begin
				vin[s] = eff[s];
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.sel)
			SEL_SHIFT: data_q <= nb;
			SEL_LOAD:  data_q <= ld;
			default:   data_q <= eff;
		endcase
		if (ctl.cap) begin
			vmin_s1 <= ctl.col_en ? min32(vin) : 8'hFF;
		end
	end

endmodule

`default_nettype wire

>>> design/dcmf_out.sv
// ----------------------------------------------------------------------------
// dcmf_out
// Horizontal minimum, transmission math and the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dcmf_out import dcmf_pkg::*; #(
	parameter int unsigned NC = 2 * MAX_RADIUS_DEF + 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               v_s1,
	input  wire pos_t               pos_s1,
	input  wire logic [NC-1:0][7:0] vmin_s1,
	input  wire logic               emit,
	input  wire logic               mode,
	input  wire logic [8:0]         factor,
	input  wire logic               out_stall,
	output logic                    out_valid,
	output out_word_t               out_data,
	output logic                    full
);

	localparam int unsigned PW = $clog2(FIFO_DEPTH);

	logic [31:0][7:0] hin;
	logic             v_s2;
	logic             v_s3;
	logic [7:0]       m_s2;
	pos_t             pos_s2;
	out_word_t        word_s3;
	logic [16:0]      prod;
	logic [7:0]       value;
	out_word_t        fifo_q [FIFO_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      cnt_q;
	logic [PW:0]      occ_q;
	logic             pop;

	always_comb begin
		hin = '1;
		for (int j = 0; j < NC; j++) begin
			hin[j] = vmin_s1[j];
		end
	end

	always_comb begin
		prod = 17'(factor) * 17'(m_s2);
		if (mode == MODE_TRANS) begin
			value = (prod >= FULL_SCALE_ROUND) ? 8'd0 : 8'((FULL_SCALE_ROUND - prod) >> 8);
		end else begin
			value = m_s2;
		end
	end

	always_ff @(posedge clk) begin
		m_s2    <= min32(hin);
		pos_s2  <= pos_s1;
		word_s3 <= '{value: value, out_row: pos_s2.row, out_col: pos_s2.col,
			last_of_frame: pos_s2.last};
		if (v_s3) begin
			fifo_q[wr_ptr_q] <= word_s3;
		end
	end

	assign pop       = out_valid && !out_stall;
	assign out_valid = cnt_q != '0;
	assign out_data  = fifo_q[rd_ptr_q];
	// credit covers the words still in the pipeline
	assign full      = occ_q == (PW+1)'(FIFO_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			occ_q    <= '0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(v_s3) - (PW+1)'(pop);
			occ_q <= occ_q + (PW+1)'(emit) - (PW+1)'(pop);
		end
	end

endmodule

`default_nettype wire

>>> design/dcmf_chk.sv
// ----------------------------------------------------------------------------
// dcmf_chk
// Port-level checks of the dark channel minimum filter.
// ----------------------------------------------------------------------------
`default_nettype none

module dcmf_chk import dcmf_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_stall,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_word_t out_data
);

	// a waiting result word is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result word dropped while stalled");

	// stalled result word keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(out_data))
		else $error("result word changed while stalled");

	// input is only refused while results are backed up
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

	// after the final word of a frame is taken, the next one starts at row and column zero
	a_last_col: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && out_data.last_of_frame) |=>
			(out_valid && !out_stall)[->1] ##0
			(out_data.out_row == 11'd0 && out_data.out_col == 11'd0))
		else $error("frame end flag malformed");

endmodule

bind dark_channel_min_filter dcmf_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
